FILE: src/srgb_tf_pkg.sv
`default_nettype none

package srgb_tf_pkg;

  // Channel formats: Q3.16 signed in, Q1.16 unsigned out (1.0 = 1 << FRAC_BITS).
  localparam int FRAC_BITS      = 16;
  localparam int TABLE_BITS_DEF = 8;
  localparam int CH_W           = 20;
  localparam int OUT_W          = FRAC_BITS + 1;

  // Encode and octave table entries and interpolation values are Q30; decode ones are Q16.
  localparam int TAB_W = 31;
  localparam int SH_W  = $clog2(FRAC_BITS);
  localparam int OCT_N = 1 << SH_W;

  // Knee path widths: input below the knee, scaled numerator, quotient.
  localparam int KX_W = 12;
  localparam int KN_W = 19;
  localparam int KQ_W = 12;

  // Encode output path widths: 1055 * p, and the value that is divided by 1000.
  localparam int NUM_W = TAB_W + 11;
  localparam int W_W   = 26;

  // Register stages from an accepted beat to the result registers.
  localparam int LATENCY = 8;

  localparam logic [63:0] Q30 = 64'd1 << 30;

  localparam logic [OUT_W-1:0] ONE_OUT = {1'b1, {FRAC_BITS{1'b0}}};

  // Largest inputs that still take the linear segment.
  localparam logic [FRAC_BITS-1:0] DEC_KNEE =
    FRAC_BITS'((64'd4045 << FRAC_BITS) / 64'd100000);
  localparam logic [FRAC_BITS-1:0] ENC_KNEE =
    FRAC_BITS'((64'd31308 << FRAC_BITS) / 64'd10000000);

  // Reciprocals rounded up; exact over the numerator ranges they see.
  localparam int          REC_W  = 20;
  localparam int          SH_DEC = 30;
  localparam int          SH_ENC = 26;
  localparam logic [REC_W-1:0] REC_DEC =
    REC_W'(((64'd1 << SH_DEC) + 64'd1291) / 64'd1292);
  localparam logic [REC_W-1:0] REC_ENC =
    REC_W'(((64'd1 << SH_ENC) + 64'd99) / 64'd100);
  localparam int          RECK_W = 27;
  localparam int          SH_K   = 36;
  localparam logic [RECK_W-1:0] REC_K =
    RECK_W'(((64'd1 << SH_K) + 64'd999) / 64'd1000);

  // Encode power segment: out = (1055 * p - 55) / 1000, rounded half up.
  localparam int               ENC_SH  = 30 - FRAC_BITS;
  localparam logic [NUM_W-1:0] ENC_MUL = NUM_W'(1055);
  localparam logic [NUM_W-1:0] ENC_SUB = NUM_W'(64'd55 << 30);
  localparam logic [NUM_W-1:0] ENC_RND = NUM_W'(64'd500 << ENC_SH);

  // Which segment a channel value falls in.
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_ONE,
    CLS_KNEE,
    CLS_POWER
  } cls_t;

  // Integer square root; used only to build table contents.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // x^(12/5) for enc = 0, x^(5/12) for enc = 1; x in (0,1] as Q30.
  function automatic logic [63:0] pow_q30(input logic [63:0] x, input logic enc);
    logic [63:0] rc [0:30];
    logic [63:0] m;
    logic [63:0] k;
    logic [63:0] fr;
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] ip;
    logic [63:0] r;
    logic [63:0] res;
    int i;
    rc[0] = Q30;
    rc[1] = isqrt64(64'd1 << 59);
    for (i = 2; i <= 30; i++) rc[i] = isqrt64(rc[i-1] << 30);
    res = '0;
    if (x != 0 && x <= Q30) begin
      m = x;
      k = '0;
      fr = '0;
      while (m < Q30) begin
        m = m << 1;
        k = k + 64'd1;
      end
      // Fraction bits of log2 by repeated squaring.
      for (i = 1; i <= 30; i++) begin
        m = (m * m) >> 30;
        if (m >= 2 * Q30) begin
          m = m >> 1;
          fr = fr | (64'd1 << (30 - i));
        end
      end
      n = k * Q30 - fr;
      q = enc ? (n * 64'd5) / 64'd12 : (n * 64'd12) / 64'd5;
      ip = q >> 30;
      q = q & (Q30 - 64'd1);
      // exp2 of the negative result as a product of root constants.
      r = Q30;
      for (i = 1; i <= 30; i++) begin
        if (q[30-i]) r = (r * rc[i]) >> 30;
      end
      if (ip < 64'd31) res = r >> ip;
    end
    return res;
  endfunction

  // Decode breakpoint k, rounded to FRAC_BITS.
  function automatic logic [63:0] dec_entry(input logic [63:0] k, input int tb);
    logic [63:0] t;
    logic [63:0] r;
    t = (((k * 64'd1000 + (64'd55 << tb)) << 30) >> tb) / 64'd1055;
    r = pow_q30(t, 1'b0);
    return (r + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  endfunction

  // Encode mantissa breakpoint k over [0.5, 1], Q30.
  function automatic logic [63:0] man_entry(input logic [63:0] k, input int tb);
    return pow_q30((64'd1 << 29) + (k << (29 - tb)), 1'b1);
  endfunction

  // Encode octave factor (2^-s)^(5/12), Q30.
  function automatic logic [63:0] oct_entry(input int s);
    return pow_q30(64'd1 << (30 - s), 1'b1);
  endfunction

endpackage

`default_nettype wire

FILE: src/srgb_tf_channel.sv
`default_nettype none

module srgb_tf_channel
  import srgb_tf_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  mode,
  input  logic signed [CH_W-1:0] x_in,
  output logic [OUT_W-1:0]      y_out
);

  localparam int TBL_N = (1 << TABLE_BITS) + 1;
  localparam int IDX_W = TABLE_BITS + 1;
  localparam int SP_W  = TAB_W + FRAC_BITS + 1;
  localparam int KP_W  = SH_DEC + KQ_W;
  localparam int PP_W  = 2 * TAB_W;
  localparam int QP_W  = SH_K + OUT_W;

  localparam logic [SP_W-1:0] STEP_RND = SP_W'(1) << (FRAC_BITS - 1);
  localparam logic [PP_W-1:0] P_RND    = PP_W'(1) << 29;

  // Constant breakpoint tables, evaluated at elaboration.
  logic [OUT_W-1:0] dec_tab [TBL_N];
  logic [TAB_W-1:0] man_tab [TBL_N];
  logic [TAB_W-1:0] oct_tab [OCT_N];

  for (genvar gk = 0; gk < TBL_N; gk++) begin : g_tab
    localparam logic [63:0] DEC_V = dec_entry(64'(gk), TABLE_BITS);
    localparam logic [63:0] MAN_V = man_entry(64'(gk), TABLE_BITS);
    assign dec_tab[gk] = DEC_V[OUT_W-1:0];
    assign man_tab[gk] = MAN_V[TAB_W-1:0];
  end

  for (genvar gs = 0; gs < OCT_N; gs++) begin : g_oct
    localparam logic [63:0] OCT_V = oct_entry(gs);
    assign oct_tab[gs] = OCT_V[TAB_W-1:0];
  end

  // Stage 1: classify, normalize for encode, split into index and fraction.
  logic [FRAC_BITS-1:0]  xl;
  logic [SH_W-1:0]       lz;
  logic [FRAC_BITS-1:0]  ynorm;
  cls_t                  cls;
  logic [TABLE_BITS-1:0] idx_sel;
  logic [FRAC_BITS-1:0]  frac_sel;

  assign xl = x_in[FRAC_BITS-1:0];

  always_comb begin
    lz = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (xl[i]) lz = SH_W'(FRAC_BITS - 1 - i);
    end
    ynorm = xl << lz;
  end

  always_comb begin
    if (x_in[CH_W-1] || x_in == '0) begin
      cls = CLS_ZERO;
    end else if (x_in[CH_W-2:FRAC_BITS] != '0) begin
      cls = CLS_ONE;
    end else if (mode ? (xl <= ENC_KNEE) : (xl <= DEC_KNEE)) begin
      cls = CLS_KNEE;
    end else begin
      cls = CLS_POWER;
    end
  end

  always_comb begin
    if (mode) begin
      idx_sel  = ynorm[FRAC_BITS-2 -: TABLE_BITS];
      frac_sel = {ynorm[FRAC_BITS-TABLE_BITS-2:0], {(TABLE_BITS+1){1'b0}}};
    end else begin
      idx_sel  = xl[FRAC_BITS-1 -: TABLE_BITS];
      frac_sel = {xl[FRAC_BITS-TABLE_BITS-1:0], {TABLE_BITS{1'b0}}};
    end
  end

  logic                  s1_mode;
  cls_t                  s1_cls;
  logic [TABLE_BITS-1:0] s1_idx;
  logic [FRAC_BITS-1:0]  s1_frac;
  logic [SH_W-1:0]       s1_sh;
  logic [KX_W-1:0]       s1_kx;

  always_ff @(posedge clk) begin
    s1_mode <= mode;
    s1_cls  <= cls;
    s1_idx  <= idx_sel;
    s1_frac <= frac_sel;
    s1_sh   <= lz;
    s1_kx   <= xl[KX_W-1:0];
  end

  // Stage 2: read both breakpoints, form the step magnitude and the knee numerator.
  logic [IDX_W-1:0] idx_lo;
  logic [IDX_W-1:0] idx_hi;
  logic [TAB_W-1:0] lo;
  logic [TAB_W-1:0] hi;
  logic [22:0]      kn_wide;

  assign idx_lo = {1'b0, s1_idx};
  assign idx_hi = idx_lo + IDX_W'(1);

  always_comb begin
    if (s1_mode) begin
      lo = man_tab[idx_lo];
      hi = man_tab[idx_hi];
      kn_wide = 23'(s1_kx) * 23'd1292 + 23'd50;
    end else begin
      lo = TAB_W'(dec_tab[idx_lo]);
      hi = TAB_W'(dec_tab[idx_hi]);
      kn_wide = 23'(s1_kx) * 23'd100 + 23'd646;
    end
  end

  logic                 s2_mode;
  cls_t                 s2_cls;
  logic [TAB_W-1:0]     s2_lo;
  logic [TAB_W-1:0]     s2_mag;
  logic                 s2_neg;
  logic [FRAC_BITS-1:0] s2_frac;
  logic [SH_W-1:0]      s2_sh;
  logic [KN_W-1:0]      s2_kn;

  always_ff @(posedge clk) begin
    s2_mode <= s1_mode;
    s2_cls  <= s1_cls;
    s2_lo   <= lo;
    s2_neg  <= hi < lo;
    s2_mag  <= (hi >= lo) ? hi - lo : lo - hi;
    s2_frac <= s1_frac;
    s2_sh   <= s1_sh;
    s2_kn   <= kn_wide[KN_W-1:0];
  end

  // Stage 3: scaled step, rounded half up; knee quotient by reciprocal.
  logic [SP_W-1:0] step_full;
  logic [KP_W-1:0] kp;
  logic [KQ_W-1:0] kq;

  assign step_full = SP_W'(s2_mag) * SP_W'(s2_frac) + STEP_RND;

  always_comb begin
    if (s2_mode) begin
      kp = KP_W'(s2_kn) * KP_W'(REC_ENC);
      kq = kp[SH_ENC +: KQ_W];
    end else begin
      kp = KP_W'(s2_kn) * KP_W'(REC_DEC);
      kq = kp[SH_DEC +: KQ_W];
    end
  end

  logic             s3_mode;
  cls_t             s3_cls;
  logic [TAB_W-1:0] s3_lo;
  logic             s3_neg;
  logic [TAB_W-1:0] s3_step;
  logic [SH_W-1:0]  s3_sh;
  logic [KQ_W-1:0]  s3_kq;

  always_ff @(posedge clk) begin
    s3_mode <= s2_mode;
    s3_cls  <= s2_cls;
    s3_lo   <= s2_lo;
    s3_neg  <= s2_neg;
    s3_step <= step_full[FRAC_BITS +: TAB_W];
    s3_sh   <= s2_sh;
    s3_kq   <= kq;
  end

  // Stage 4: finish the interpolation and fetch the octave factor.
  logic             s4_mode;
  cls_t             s4_cls;
  logic [TAB_W-1:0] s4_mv;
  logic [TAB_W-1:0] s4_oct;
  logic [KQ_W-1:0]  s4_kq;

  always_ff @(posedge clk) begin
    s4_mode <= s3_mode;
    s4_cls  <= s3_cls;
    s4_mv   <= s3_neg ? s3_lo - s3_step : s3_lo + s3_step;
    s4_oct  <= oct_tab[s3_sh];
    s4_kq   <= s3_kq;
  end

  // Stage 5: undo the encode normalization; clamp the decode result.
  logic [PP_W-1:0] pp;

  assign pp = PP_W'(s4_mv) * PP_W'(s4_oct) + P_RND;

  logic             s5_mode;
  cls_t             s5_cls;
  logic [TAB_W-1:0] s5_p;
  logic [OUT_W-1:0] s5_dec;
  logic [KQ_W-1:0]  s5_kq;

  always_ff @(posedge clk) begin
    s5_mode <= s4_mode;
    s5_cls  <= s4_cls;
    s5_p    <= pp[30 +: TAB_W];
    s5_dec  <= (s4_mv > TAB_W'(ONE_OUT)) ? ONE_OUT : s4_mv[OUT_W-1:0];
    s5_kq   <= s4_kq;
  end

  // Stage 6: scale by 1.055, remove the 0.055 offset, round to FRAC_BITS.
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] wsum;

  assign num  = NUM_W'(s5_p) * ENC_MUL;
  assign wsum = num - ENC_SUB + ENC_RND;

  logic             s6_mode;
  cls_t             s6_cls;
  logic             s6_pos;
  logic [W_W-1:0]   s6_w;
  logic [OUT_W-1:0] s6_dec;
  logic [KQ_W-1:0]  s6_kq;

  always_ff @(posedge clk) begin
    s6_mode <= s5_mode;
    s6_cls  <= s5_cls;
    s6_pos  <= num > ENC_SUB;
    s6_w    <= wsum[ENC_SH +: W_W];
    s6_dec  <= s5_dec;
    s6_kq   <= s5_kq;
  end

  // Stage 7: divide by 1000 through the reciprocal.
  logic [QP_W-1:0] qp;

  assign qp = QP_W'(s6_w) * QP_W'(REC_K);

  logic             s7_mode;
  cls_t             s7_cls;
  logic             s7_pos;
  logic [OUT_W-1:0] s7_q;
  logic [OUT_W-1:0] s7_dec;
  logic [KQ_W-1:0]  s7_kq;

  always_ff @(posedge clk) begin
    s7_mode <= s6_mode;
    s7_cls  <= s6_cls;
    s7_pos  <= s6_pos;
    s7_q    <= qp[SH_K +: OUT_W];
    s7_dec  <= s6_dec;
    s7_kq   <= s6_kq;
  end

  // Stage 8: pick the segment's result.
  logic [OUT_W-1:0] y_next;

  always_comb begin
    case (s7_cls)
      CLS_ZERO:  y_next = '0;
      CLS_ONE:   y_next = ONE_OUT;
      CLS_KNEE:  y_next = OUT_W'(s7_kq);
      CLS_POWER: begin
        if (!s7_mode) begin
          y_next = s7_dec;
        end else if (!s7_pos) begin
          y_next = '0;
        end else begin
          y_next = (s7_q > ONE_OUT) ? ONE_OUT : s7_q;
        end
      end
      default:   y_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    y_out <= y_next;
  end

endmodule

`default_nettype wire

FILE: src/srgb_transfer_function_unit.sv
`default_nettype none

// Channel   Ports                                  Direction  Handshake
// command   start, mode, red_in, green_in, blue_in in         beat taken on start && !busy
// status    busy                                   out        high only during reset
// result    done, red_out, green_out, blue_out     out        one-cycle strobe, no back-pressure
//
// One pixel is taken every clock while busy is low; results come out of the channel
// pipeline of register stages s1 to s7 and the output register, whose longest steps are the
// Q30 octave product and the divide by 1000 of the encode path.
// Reset clears the valid bits; no result is strobed for beats before reset.
// The receiver cannot stall, so the pipeline always advances.
module srgb_transfer_function_unit
  import srgb_tf_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   mode,
  input  logic signed [CH_W-1:0] red_in,
  input  logic signed [CH_W-1:0] green_in,
  input  logic signed [CH_W-1:0] blue_in,
  output logic                   done,
  output logic [OUT_W-1:0]       red_out,
  output logic [OUT_W-1:0]       green_out,
  output logic [OUT_W-1:0]       blue_out
);

  // The unit holds off new beats only while reset is applied.
  assign busy = rst;

  // Valid bits that travel alongside the channel pipelines.
  logic [LATENCY-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  assign done = vld[LATENCY-1];

  // One conversion pipeline per color channel.
  srgb_tf_channel #(
    .TABLE_BITS(TABLE_BITS)
  ) u_red (
    .clk  (clk),
    .mode (mode),
    .x_in (red_in),
    .y_out(red_out)
  );

  srgb_tf_channel #(
    .TABLE_BITS(TABLE_BITS)
  ) u_green (
    .clk  (clk),
    .mode (mode),
    .x_in (green_in),
    .y_out(green_out)
  );

  srgb_tf_channel #(
    .TABLE_BITS(TABLE_BITS)
  ) u_blue (
    .clk  (clk),
    .mode (mode),
    .x_in (blue_in),
    .y_out(blue_out)
  );

  // A result strobe always traces back to an accepted input beat.
  a_done_has_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching input beat");

  // Every result lies within [0, 1].
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (red_out <= ONE_OUT && green_out <= ONE_OUT && blue_out <= ONE_OUT))
    else $error("converted channel above one");

  // A negative red input comes out as zero in its result beat.
  a_neg_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && red_in[CH_W-1]) |-> ##LATENCY (done && red_out == '0))
    else $error("negative input did not convert to zero");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
  import srgb_tf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LUT_BITS      = TABLE_BITS_DEF;
  localparam int  LUT_LAST      = 1 << LUT_BITS;
  localparam bit  MODE_EXPAND   = 1'b0;
  localparam bit  MODE_COMPRESS = 1'b1;
  localparam int  PIXEL_COUNT   = 850;
  localparam int  CALM_TAIL     = 100;
  localparam int  DRAIN_LIMIT   = 10000;
  localparam longint unsigned ONE_CH = 64'd1 << FRAC_BITS;

  typedef struct {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } out_pixel_t;

  typedef struct {
    bit                   mode;
    logic signed [CH_W-1:0] red;
    logic signed [CH_W-1:0] green;
    logic signed [CH_W-1:0] blue;
    bit                   known;
    out_pixel_t           result;
  } pixel_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   mode = MODE_EXPAND;
  logic signed [CH_W-1:0] red_in = '0;
  logic signed [CH_W-1:0] green_in = '0;
  logic signed [CH_W-1:0] blue_in = '0;
  logic                   done;
  logic [OUT_W-1:0]       red_out;
  logic [OUT_W-1:0]       green_out;
  logic [OUT_W-1:0]       blue_out;

  // Typed-in result travelling with the beat, when the row has one.
  bit                     row_known = 1'b0;
  out_pixel_t             row_result;

  longint unsigned root_lut [0:30];
  longint unsigned gamma_dec_lut [0:LUT_LAST];
  longint unsigned gamma_man_lut [0:LUT_LAST];
  longint unsigned gamma_oct_lut [0:15];

  out_pixel_t awaited_pixels [$];
  pixel_row_t directed_rows [$];
  int         error_count = 0;

  srgb_transfer_function_unit #(
    .TABLE_BITS(LUT_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .done     (done),
    .red_out  (red_out),
    .green_out(green_out),
    .blue_out (blue_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // x^(num/den) for x in (0,1], all values Q30.
  function automatic longint unsigned q30_power(longint unsigned x, int unsigned num,
                                               int unsigned den);
    longint unsigned m;
    longint unsigned k;
    longint unsigned fr;
    longint unsigned n;
    longint unsigned q;
    longint unsigned ip;
    longint unsigned r;
    int i;
    if (x == 0 || x > Q30 || den == 0) return 0;
    m = x;
    k = 0;
    fr = 0;
    while (m < Q30) begin
      m = m << 1;
      k++;
    end
    // Log2 fraction bits by repeated squaring, each step truncated.
    for (i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= 2 * Q30) begin
        m = m >> 1;
        fr = fr | (64'd1 << (30 - i));
      end
    end
    n = k * Q30 - fr;
    q = n * num / den;
    ip = q >> 30;
    q = q & (Q30 - 1);
    // Rebuild 2^-q from the chain of square roots of one half.
    r = Q30;
    for (i = 1; i <= 30; i++) begin
      if ((q >> (30 - i)) & 1) r = (r * root_lut[i]) >> 30;
    end
    if (ip >= 31) return 0;
    return r >> ip;
  endfunction

  // Linear interpolation between breakpoints, step rounded half up in magnitude.
  function automatic longint unsigned lut_interp(bit enc, longint unsigned idx,
                                                 longint unsigned frac);
    longint unsigned lo;
    longint unsigned hi;
    if (idx >= LUT_LAST) idx = LUT_LAST - 1;
    lo = enc ? gamma_man_lut[idx] : gamma_dec_lut[idx];
    hi = enc ? gamma_man_lut[idx + 1] : gamma_dec_lut[idx + 1];
    if (hi >= lo) return lo + (((hi - lo) * frac + (ONE_CH >> 1)) >> FRAC_BITS);
    return lo - (((lo - hi) * frac + (ONE_CH >> 1)) >> FRAC_BITS);
  endfunction

  // Expected output of one channel for the given direction.
  function automatic logic [OUT_W-1:0] srgb_convert_channel(logic signed [CH_W-1:0] raw,
                                                            bit enc);
    longint unsigned x;
    longint unsigned y;
    longint unsigned s;
    longint unsigned pos;
    longint unsigned mv;
    longint unsigned p;
    longint unsigned num;
    longint unsigned val;
    cls_t            cls;
    x = longint'(unsigned'(raw));
    if (raw[CH_W-1] || x == 0) cls = CLS_ZERO;
    else if (x >= ONE_CH) cls = CLS_ONE;
    else if (!enc && x * 100000 <= 4045 * ONE_CH) cls = CLS_KNEE;
    else if (enc && x * 10000000 <= 31308 * ONE_CH) cls = CLS_KNEE;
    else cls = CLS_POWER;
    val = 0;
    case (cls)
      CLS_ZERO: val = 0;
      CLS_ONE: val = ONE_CH;
      CLS_KNEE: begin
        if (enc) val = (x * 1292 + 50) / 100;
        else val = (x * 100 + 646) / 1292;
      end
      CLS_POWER: begin
        if (!enc) begin
          pos = x << LUT_BITS;
          val = lut_interp(1'b0, pos >> FRAC_BITS, pos & (ONE_CH - 1));
        end else begin
          // Normalize into [0.5,1), interpolate the mantissa, then scale by octave.
          y = x;
          s = 0;
          while (y < (ONE_CH >> 1) && s < 15) begin
            y = y << 1;
            s++;
          end
          if (y < (ONE_CH >> 1)) y = ONE_CH >> 1;
          pos = (y - (ONE_CH >> 1)) << (LUT_BITS + 1);
          mv = lut_interp(1'b1, pos >> FRAC_BITS, pos & (ONE_CH - 1));
          p = (mv * gamma_oct_lut[s] + (64'd1 << 29)) >> 30;
          num = 1055 * p;
          if (num <= 55 * Q30) begin
            val = 0;
          end else begin
            val = (num - 55 * Q30 + (64'd500 << (30 - FRAC_BITS))) /
                  (64'd1000 << (30 - FRAC_BITS));
          end
        end
        if (val > ONE_CH) val = ONE_CH;
      end
      default: val = 0;
    endcase
    return OUT_W'(val);
  endfunction

  // Random channel value, weighted toward the interesting segments.
  function automatic logic signed [CH_W-1:0] random_channel(bit enc);
    int unsigned knee;
    knee = ($urandom_range(0, 1) == 1) ? (enc ? 205 : 2650) : (enc ? 2650 : 205);
    case ($urandom_range(0, 9))
      0: return CH_W'($urandom());
      1: return -CH_W'($urandom_range(1, 524288));
      2: return CH_W'($urandom_range(65536, 524287));
      3: return ($urandom_range(0, 1) == 1) ? CH_W'(65536) : CH_W'(0);
      4: return CH_W'(knee - 8 + $urandom_range(0, 16));
      5: return CH_W'($urandom_range(1, 4096));
      default: return CH_W'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic void add_row(bit m, int r, int g, int b, bit known,
                                  int er, int eg, int eb);
    pixel_row_t row;
    row.mode = m;
    row.red = CH_W'(r);
    row.green = CH_W'(g);
    row.blue = CH_W'(b);
    row.known = known;
    row.result.red = OUT_W'(er);
    row.result.green = OUT_W'(eg);
    row.result.blue = OUT_W'(eb);
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [OUT_W-1:0] expected,
                                      logic [OUT_W-1:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endfunction

  // Present one pixel and hold it until the block takes the beat.
  task automatic send_pixel(pixel_row_t row);
    start <= 1'b1;
    mode <= row.mode;
    red_in <= row.red;
    green_in <= row.green;
    blue_in <= row.blue;
    row_known <= row.known;
    row_result <= row.result;
    do @(posedge clk); while (busy);
  endtask

  // Constant breakpoint tables, built once with exact integer arithmetic.
  initial begin
    longint unsigned v;
    longint unsigned r;
    longint unsigned probe;
    longint unsigned t;
    int i;
    int k;
    root_lut[0] = Q30;
    for (i = 1; i <= 30; i++) begin
      v = (i == 1) ? (64'd1 << 59) : (root_lut[i - 1] << 30);
      r = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
        if (v >= r + probe) begin
          v = v - (r + probe);
          r = (r >> 1) + probe;
        end else begin
          r = r >> 1;
        end
        probe = probe >> 2;
      end
      root_lut[i] = r;
    end
    for (k = 0; k <= LUT_LAST; k++) begin
      t = ((longint'(k) * 1000 + 55 * LUT_LAST) << 30) / (1055 * LUT_LAST);
      gamma_dec_lut[k] = (q30_power(t, 12, 5) + (64'd1 << (29 - FRAC_BITS))) >>
                         (30 - FRAC_BITS);
      gamma_man_lut[k] = q30_power((64'd1 << 29) + (longint'(k) << (29 - LUT_BITS)), 5, 12);
    end
    for (i = 0; i < 16; i++) gamma_oct_lut[i] = q30_power(64'd1 << (30 - i), 5, 12);
  end

  // Result check first, then record the expectation for a beat taken at this edge.
  always @(posedge clk) begin
    out_pixel_t want;
    out_pixel_t got;
    if (!rst) begin
      if (done) begin
        got.red = red_out;
        got.green = green_out;
        got.blue = blue_out;
        if (awaited_pixels.size() == 0) begin
          $error("result beat with no pixel outstanding: %0d %0d %0d",
                 got.red, got.green, got.blue);
          error_count++;
        end else begin
          want = awaited_pixels.pop_front();
          check_field("red_out", want.red, got.red);
          check_field("green_out", want.green, got.green);
          check_field("blue_out", want.blue, got.blue);
        end
      end
      if (start && !busy) begin
        if (row_known) begin
          want = row_result;
        end else begin
          want.red = srgb_convert_channel(red_in, mode);
          want.green = srgb_convert_channel(green_in, mode);
          want.blue = srgb_convert_channel(blue_in, mode);
        end
        awaited_pixels.push_back(want);
      end
    end
  end

  // Stimulus: directed rows, then random pixels with bursts of idle cycles.
  initial begin
    pixel_row_t row;
    int         i;
    int         drained;
    // Zero, negatives and saturation read straight off the transfer function.
    add_row(MODE_EXPAND, 0, 0, 0, 1, 0, 0, 0);
    add_row(MODE_COMPRESS, 0, 0, 0, 1, 0, 0, 0);
    add_row(MODE_EXPAND, -1, -524288, -65536, 1, 0, 0, 0);
    add_row(MODE_COMPRESS, -1, -524288, -65536, 1, 0, 0, 0);
    add_row(MODE_EXPAND, 65536, 524287, 131072, 1, 65536, 65536, 65536);
    add_row(MODE_COMPRESS, 65536, 524287, 131072, 1, 65536, 65536, 65536);
    add_row(MODE_EXPAND, -524288, 524287, 0, 1, 0, 65536, 0);
    // Linear segment at the smallest code and right at each knee.
    add_row(MODE_EXPAND, 1, 2650, 1, 1, 0, 205, 0);
    add_row(MODE_COMPRESS, 1, 205, 1, 1, 13, 2649, 13);
    // Power segment just past the knees, mid scale and just below one, mixed with other segments.
    add_row(MODE_EXPAND, 2651, 65535, 32768, 0, 0, 0, 0);
    add_row(MODE_COMPRESS, 206, 65535, 32768, 0, 0, 0, 0);
    add_row(MODE_COMPRESS, 2651, 2650, 16384, 0, 0, 0, 0);
    add_row(MODE_EXPAND, 205, 206, 256, 0, 0, 0, 0);
    add_row(MODE_COMPRESS, 300, 1000, 4096, 0, 0, 0, 0);
    add_row(MODE_EXPAND, 16384, 49152, 65280, 0, 0, 0, 0);
    add_row(MODE_COMPRESS, 65280, 32767, 8192, 0, 0, 0, 0);
    add_row(MODE_COMPRESS, -1, 65536, 65535, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[j]) send_pixel(directed_rows[j]);

    row.known = 1'b0;
    row.result = '{default: '0};
    for (i = directed_rows.size(); i < PIXEL_COUNT; i++) begin
      // Hold off once until every pixel in flight has come back.
      if (i == PIXEL_COUNT / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (awaited_pixels.size() != 0);
      end else if (i < PIXEL_COUNT - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      row.mode = $urandom_range(0, 1);
      row.red = random_channel(row.mode);
      row.green = random_channel(row.mode);
      row.blue = random_channel(row.mode);
      send_pixel(row);
    end
    start <= 1'b0;
    row_known <= 1'b0;

    drained = 0;
    while (awaited_pixels.size() != 0 && drained < DRAIN_LIMIT) begin
      @(posedge clk);
      drained++;
    end
    repeat (LATENCY + 8) @(posedge clk);
    if (awaited_pixels.size() != 0) begin
      $error("%0d pixels never came back", awaited_pixels.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
